>>> rtl/imufs_pkg.sv
`timescale 1ns / 1ps

package imufs_pkg;

   localparam int FRAME_LEN = 11;
   // bytes held ahead of the closing (checksum) byte
   localparam int HOLD_LEN  = FRAME_LEN - 1;

   typedef logic [7:0]          byte_type;
   typedef logic [3:0]          fill_type;
   typedef logic [1:0]          kind_type;
   typedef logic signed [15:0]  raw_type;
   typedef logic signed [12:0]  scale_type;
   typedef logic signed [27:0]  axis_type;
   typedef logic signed [24:0]  temp_type;

   localparam byte_type HDR_SYNC = 8'h55;
   localparam byte_type HDR_ACC  = 8'h51;
   localparam byte_type HDR_GYR  = 8'h52;
   localparam byte_type HDR_ANG  = 8'h53;

   localparam kind_type KIND_ACC = 2'd0;
   localparam kind_type KIND_GYR = 2'd1;
   localparam kind_type KIND_ANG = 2'd2;

   // Q16.16 per raw count: 16 g, 2000 deg/s and 180 deg over 32768 counts
   localparam scale_type SCALE_ACC = 13'sd32;
   localparam scale_type SCALE_GYR = 13'sd4000;
   localparam scale_type SCALE_ANG = 13'sd360;

   // floor(raw * 16384 / 85): bias the numerator by 85 * 6316129 so it is
   // never negative, divide by reciprocal, then take the bias back out
   localparam logic [29:0] TEMP_BIAS   = 30'd536870965;
   localparam logic [30:0] TEMP_RECIP  = 31'd1616928865;  // ceil(2^37 / 85)
   localparam int          TEMP_SHIFT  = 37;
   localparam int          TEMP_QBITS  = 24;
   // 6316129 minus the 36.25 degree offset (2375680 in Q16.16)
   localparam temp_type    TEMP_OFFSET = 25'sd3940449;

   typedef struct packed {
      kind_type kind;
      raw_type  x;
      raw_type  y;
      raw_type  z;
      raw_type  temp;
   } frame_type;

   typedef struct packed {
      kind_type kind;
      axis_type x;
      axis_type y;
      axis_type z;
      temp_type temp;
   } result_type;

endpackage

>>> rtl/imufs_req_if.sv
`timescale 1ns / 1ps

interface imufs_req_if;
   import imufs_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/imufs_rsp_if.sv
`timescale 1ns / 1ps

interface imufs_rsp_if;
   import imufs_pkg::*;

   logic     valid;
   logic     ready;
   kind_type frame_kind;
   axis_type axis_x;
   axis_type axis_y;
   axis_type axis_z;
   temp_type temperature;

   modport source (output valid, output frame_kind, output axis_x, output axis_y,
                   output axis_z, output temperature, input ready);
   modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                   input axis_z, input temperature, output ready);
endinterface

>>> rtl/imu_frame_sync_decoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Word
// req_if   in   valid/ready    rx_byte (one serial byte)
// rsp_if   out  valid/ready    frame_kind, axis_x, axis_y, axis_z, temperature
//
// One byte is taken per cycle while req_if.ready is high. A frame's result passes through
// the frame register and then the result register before it shows on rsp_if.
// Reset (synchronous) empties the window and both stages.
// A stalled result holds in the result register while the frame register takes
// the next frame; req_if.ready drops only while both registers are full.

module imu_frame_sync_decoder (
   input logic          clock,
   input logic          reset,
   imufs_req_if.sink    req_if,
   imufs_rsp_if.source  rsp_if
);
   import imufs_pkg::*;

   byte_type   window_ff [HOLD_LEN];
   fill_type   fill_ff, fill_in;
   frame_type  frame_ff, frame_in;
   logic       frame_valid_ff, frame_valid_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic       out_load, frame_free, req_fire, at_close, header_ok, frame_load;
   scale_type  scale;
   logic signed [28:0] prod_x, prod_y, prod_z;
   logic [29:0] temp_biased;
   logic [60:0] temp_prod;
   logic [TEMP_QBITS-1:0] temp_quot;

   assign out_load   = frame_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign frame_free = !frame_valid_ff || out_load;
   assign req_if.ready = frame_free;
   assign req_fire   = req_if.valid && frame_free;

   // the incoming byte closes the frame; it is the checksum and is not examined
   assign at_close  = (fill_ff == fill_type'(HOLD_LEN));
   assign header_ok = (window_ff[0] == HDR_SYNC) &&
                      (window_ff[1] == HDR_ACC || window_ff[1] == HDR_GYR ||
                       window_ff[1] == HDR_ANG);
   assign frame_load = req_fire && at_close && header_ok;

   always_comb begin
      fill_in = fill_ff;
      if (req_fire) begin
         if (!at_close) begin
            fill_in = fill_ff + 4'd1;
         end else if (header_ok) begin
            fill_in = '0;
         end else begin
            fill_in = fill_type'(HOLD_LEN);
         end
      end
   end

   always_comb begin
      case (window_ff[1])
         HDR_ACC: frame_in.kind = KIND_ACC;
         HDR_GYR: frame_in.kind = KIND_GYR;
         default: frame_in.kind = KIND_ANG;
      endcase
      frame_in.x    = {window_ff[3], window_ff[2]};
      frame_in.y    = {window_ff[5], window_ff[4]};
      frame_in.z    = {window_ff[7], window_ff[6]};
      frame_in.temp = {window_ff[9], window_ff[8]};
   end

   assign frame_valid_in = frame_load ? 1'b1 : (out_load ? 1'b0 : frame_valid_ff);

   always_comb begin
      case (frame_ff.kind)
         KIND_ACC: scale = SCALE_ACC;
         KIND_GYR: scale = SCALE_GYR;
         default:  scale = SCALE_ANG;
      endcase
   end

   assign prod_x = frame_ff.x * scale;
   assign prod_y = frame_ff.y * scale;
   assign prod_z = frame_ff.z * scale;

   // biased numerator lies in [53, 2^30), so the 30-bit wraparound sum is exact
   assign temp_biased = {frame_ff.temp, 14'b0} + TEMP_BIAS;
   assign temp_prod   = 61'(temp_biased) * 61'(TEMP_RECIP);
   assign temp_quot   = temp_prod[TEMP_SHIFT +: TEMP_QBITS];

   always_comb begin
      out_in.kind = frame_ff.kind;
      out_in.x    = prod_x[27:0];
      out_in.y    = prod_y[27:0];
      out_in.z    = prod_z[27:0];
      out_in.temp = $signed({1'b0, temp_quot}) - TEMP_OFFSET;
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         frame_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         frame_valid_ff <= frame_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (!at_close) begin
            window_ff[fill_ff] <= req_if.rx_byte;
         end else if (!header_ok) begin
            // drop the oldest byte, the closing byte moves into the last slot
            for (int i = 0; i < HOLD_LEN - 1; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[HOLD_LEN-1] <= req_if.rx_byte;
         end
      end
      if (frame_load) begin
         frame_ff <= frame_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.frame_kind  = out_ff.kind;
   assign rsp_if.axis_x      = out_ff.x;
   assign rsp_if.axis_y      = out_ff.y;
   assign rsp_if.axis_z      = out_ff.z;
   assign rsp_if.temperature = out_ff.temp;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fill_type'(HOLD_LEN))
      else $error("window fill count past the held length");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      frame_load |=> (fill_ff == '0) && frame_valid_ff)
      else $error("decoded frame did not empty the window");

   a_bad_header_slides: assert property (@(posedge clock) disable iff (reset)
      (req_fire && at_close && !header_ok) |=>
         (fill_ff == fill_type'(HOLD_LEN)) && (window_ff[HOLD_LEN-1] == $past(req_if.rx_byte)))
      else $error("bad header did not slide the window by one byte");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff && (out_ff.kind == $past(frame_ff.kind)))
      else $error("frame register did not move into the result register");

endmodule

>>> sim/imufs_frame_checker.sv
`timescale 1ns / 1ps

module imufs_frame_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  imufs_pkg::byte_type   req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  imufs_pkg::kind_type   rsp_frame_kind,
   input  imufs_pkg::axis_type   rsp_axis_x,
   input  imufs_pkg::axis_type   rsp_axis_y,
   input  imufs_pkg::axis_type   rsp_axis_z,
   input  imufs_pkg::temp_type   rsp_temperature,
   output int                    fail_count,
   output int                    pending_results
);
   import imufs_pkg::*;

   localparam longint CELSIUS_DIV   = 340;
   localparam longint TEMP_BASE_Q16 = 2375680;   // 36.25 degrees
   localparam int     PRINT_LIMIT   = 40;

   result_type expected_frames[$];
   byte_type   window_bytes[FRAME_LEN];
   int         fill_level;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t ERROR: %s", $time, msg);
      end
   endtask

   task automatic clear_window();
      int i;
      for (i = 0; i < FRAME_LEN; i++) begin
         window_bytes[i] = '0;
      end
      fill_level = 0;
   endtask

   function automatic raw_type word_from(input int lo);
      raw_type w;
      w = {window_bytes[lo + 1], window_bytes[lo]};
      return w;
   endfunction

   function automatic axis_type scale_axis(input raw_type raw, input scale_type scale);
      longint   prod;
      axis_type a;
      prod = longint'(raw) * longint'(scale);
      a = prod[27:0];
      return a;
   endfunction

   // floor division: round toward minus infinity for negative raw
   function automatic temp_type celsius_q16(input raw_type raw);
      longint   num;
      longint   quo;
      longint   sum;
      temp_type t;
      num = longint'(raw) * 65536;
      quo = num / CELSIUS_DIV;
      if ((num % CELSIUS_DIV) != 0 && num < 0) begin
         quo = quo - 1;
      end
      sum = quo + TEMP_BASE_Q16;
      t = sum[24:0];
      return t;
   endfunction

   task automatic accept_byte(input byte_type b);
      result_type frame;
      scale_type  scale;
      int         i;
      if (fill_level < FRAME_LEN) begin
         window_bytes[fill_level] = b;
         fill_level++;
      end
      if (fill_level == FRAME_LEN) begin
         if (window_bytes[0] != HDR_SYNC ||
             (window_bytes[1] != HDR_ACC && window_bytes[1] != HDR_GYR &&
              window_bytes[1] != HDR_ANG)) begin
            // drop the oldest byte and wait for one more
            for (i = 1; i < FRAME_LEN; i++) begin
               window_bytes[i - 1] = window_bytes[i];
            end
            window_bytes[FRAME_LEN - 1] = '0;
            fill_level = FRAME_LEN - 1;
         end else begin
            case (window_bytes[1])
               HDR_ACC: begin
                  frame.kind = KIND_ACC;
                  scale = SCALE_ACC;
               end
               HDR_GYR: begin
                  frame.kind = KIND_GYR;
                  scale = SCALE_GYR;
               end
               default: begin
                  frame.kind = KIND_ANG;
                  scale = SCALE_ANG;
               end
            endcase
            frame.x    = scale_axis(word_from(2), scale);
            frame.y    = scale_axis(word_from(4), scale);
            frame.z    = scale_axis(word_from(6), scale);
            frame.temp = celsius_q16(word_from(8));
            expected_frames.push_back(frame);
            clear_window();
         end
      end
   endtask

   task automatic check_result();
      result_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("result word with no frame pending (kind %0d)",
                                   rsp_frame_kind));
      end else begin
         want = expected_frames.pop_front();
         if (rsp_frame_kind !== want.kind)
            report_mismatch($sformatf("frame_kind got %0d expected %0d",
                                      rsp_frame_kind, want.kind));
         if (rsp_axis_x !== want.x)
            report_mismatch($sformatf("axis_x got %0d expected %0d", rsp_axis_x, want.x));
         if (rsp_axis_y !== want.y)
            report_mismatch($sformatf("axis_y got %0d expected %0d", rsp_axis_y, want.y));
         if (rsp_axis_z !== want.z)
            report_mismatch($sformatf("axis_z got %0d expected %0d", rsp_axis_z, want.z));
         if (rsp_temperature !== want.temp)
            report_mismatch($sformatf("temperature got %0d expected %0d",
                                      rsp_temperature, want.temp));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_window();
         expected_frames.delete();
      end else begin
         // a result is registered behind its closing byte, so pop before push
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) accept_byte(req_rx_byte);
      end
      pending_results = expected_frames.size();
   end

endmodule

>>> sim/imu_frame_sync_decoder_tb.sv
`timescale 1ns / 1ps

module imu_frame_sync_decoder_tb;
   import imufs_pkg::*;

   localparam int BYTE_TARGET  = 950;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imufs_req_if req_if ();
   imufs_rsp_if rsp_if ();

   int fail_count;
   int pending_results;
   int burst_left;
   int bytes_sent;
   int idle_cycles;
   bit hold_rsp;
   bit no_gaps;

   imu_frame_sync_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   imufs_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_rx_byte     (req_if.rx_byte),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_frame_kind  (rsp_if.frame_kind),
      .rsp_axis_x      (rsp_if.axis_x),
      .rsp_axis_y      (rsp_if.axis_y),
      .rsp_axis_z      (rsp_if.axis_z),
      .rsp_temperature (rsp_if.temperature),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ready is checked mid-cycle, so the word is taken at the next rising edge
   task automatic send_byte(input byte_type b);
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic put_byte(input byte_type b);
      if (burst_left <= 0) begin
         if (!no_gaps && $urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 12))
               @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      send_byte(b);
      burst_left--;
   endtask

   task automatic send_frame(input byte_type kind_hdr, input raw_type x, input raw_type y,
                             input raw_type z, input raw_type t, input byte_type sum,
                             input int len);
      byte_type bytes[FRAME_LEN];
      int       i;
      bytes = '{HDR_SYNC, kind_hdr, x[7:0], x[15:8], y[7:0], y[15:8],
                z[7:0], z[15:8], t[7:0], t[15:8], sum};
      for (i = 0; i < len; i++) begin
         put_byte(bytes[i]);
      end
   endtask

   function automatic raw_type rand_raw();
      raw_type r;
      case ($urandom_range(0, 7))
         0:       r = 16'sh7fff;
         1:       r = 16'sh8000;
         2:       r = 16'sh0000;
         3:       r = 16'shffff;
         default: r = raw_type'($urandom);
      endcase
      return r;
   endfunction

   function automatic byte_type rand_kind_hdr();
      byte_type h;
      case ($urandom_range(0, 2))
         0:       h = HDR_ACC;
         1:       h = HDR_GYR;
         default: h = HDR_ANG;
      endcase
      return h;
   endfunction

   task automatic send_random_frame(input byte_type kind_hdr, input int len);
      send_frame(kind_hdr, rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                 byte_type'($urandom), len);
   endtask

   // lower valid and hold until every pending result has been taken
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   initial begin
      int  choice;
      int  n;
      int  i;
      bit  pressure_done;
      bit  drain_done;
      byte_type b;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bad kind byte ahead of a frame, then full-scale words of each kind
      put_byte(HDR_SYNC);
      put_byte(8'h54);
      send_frame(HDR_ACC, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 8'h00, FRAME_LEN);
      put_byte(8'h00);
      send_frame(HDR_GYR, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh8000, 8'hff, FRAME_LEN);
      put_byte(HDR_SYNC);
      put_byte(8'h50);
      send_frame(HDR_ANG, 16'shffff, 16'sh0001, 16'sh8000, 16'sh0000, 8'haa, FRAME_LEN);

      while (bytes_sent < BYTE_TARGET) begin
         if (!pressure_done && bytes_sent >= 300) begin
            // stall the result side and keep offering frames back to back
            hold_rsp = 1'b1;
            no_gaps  = 1'b1;
            repeat (5) send_random_frame(rand_kind_hdr(), FRAME_LEN);
            no_gaps  = 1'b0;
            pressure_done = 1'b1;
         end else if (!drain_done && bytes_sent >= 600) begin
            wait_drained();
            drain_done = 1'b1;
         end else begin
            choice = $urandom_range(0, 19);
            if (choice <= 13) begin
               send_random_frame(rand_kind_hdr(), FRAME_LEN);
            end else if (choice <= 15) begin
               n = $urandom_range(1, 6);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 3))
                     0:       b = HDR_SYNC;
                     1:       b = rand_kind_hdr();
                     default: b = byte_type'($urandom);
                  endcase
                  put_byte(b);
               end
            end else if (choice <= 17) begin
               send_random_frame(rand_kind_hdr(), $urandom_range(2, FRAME_LEN - 1));
            end else begin
               send_random_frame(byte_type'($urandom), FRAME_LEN);
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side: ready pattern redrawn at random from four modes, plus one long hold-off
   initial begin
      int cyc;
      int mode;
      bit hold_taken;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ((cyc % 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> imu_frame_sync_decoder.f
rtl/imufs_pkg.sv
rtl/imufs_req_if.sv
rtl/imufs_rsp_if.sv
rtl/imu_frame_sync_decoder.sv
sim/imufs_frame_checker.sv
sim/imu_frame_sync_decoder_tb.sv
